[hdl/tkls_pkg.sv]
package tkls_pkg;

  localparam int LoadW  = 32;
  localparam int IdW    = 22;
  localparam int PosW   = 16;
  localparam int RankW  = 6;
  localparam int CountW = 7;

  localparam int TopCountDefault = 8;
  localparam int MaxListDefault  = 65536;

  typedef struct packed {
    logic [LoadW-1:0] load_value;
    logic [IdW-1:0]   entry_id;
    logic [PosW-1:0]  list_position;
    logic             valid;
  } entry_t;

  // An entry ranks higher on a higher load, and on equal loads on the lower id.
  function automatic logic precedes(input entry_t a, input entry_t b);
    logic result;
    if (a.load_value != b.load_value) begin
      result = a.load_value > b.load_value;
    end else begin
      result = a.entry_id < b.entry_id;
    end
    return result;
  endfunction

endpackage

[hdl/tkls_in_if.sv]
interface tkls_in_if
  import tkls_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [LoadW-1:0] load_value;
  logic [IdW-1:0]   entry_id;
  logic             usable;
  logic             last_entry;

  modport source (output valid, load_value, entry_id, usable, last_entry, input ready);
  modport sink (input valid, load_value, entry_id, usable, last_entry, output ready);
endinterface

[hdl/tkls_out_if.sv]
interface tkls_out_if
  import tkls_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [RankW-1:0]  rank;
  logic [PosW-1:0]   list_position;
  logic              present;
  logic [CountW-1:0] selected_count;
  logic              last_result;

  modport source (output valid, rank, list_position, present, selected_count, last_result,
                  input ready);
  modport sink (input valid, rank, list_position, present, selected_count, last_result,
                output ready);
endinterface

[hdl/top_k_load_selector.sv]
// Top-k load selector.
// Requests arrive on the entries channel, one list entry per request, and the
// best TOP_COUNT entries are kept in a chain of cells sorted by load, ties going
// to the lower id. Each cell compares the newcomer with its own entry and takes
// either the newcomer or its upper neighbour, so one request is accepted every
// cycle while a list streams in.
// A request marked last_entry is inserted like any other and then starts the
// read-out: the chain shifts towards rank 0 one place per cycle while the output
// register is free, and TOP_COUNT results leave on the results channel, the
// first once the read-out state loads the output register. No request is
// accepted during read-out, and the next list may start as soon as the final
// result sits in the output register.
// A stalled receiver holds the output register and pauses the read-out.
// Positions past MAX_LIST are counted no further and not inserted.
// Reset empties the chain and clears the position and fill counters.
module top_k_load_selector
  import tkls_pkg::*;
#(
  parameter int TOP_COUNT = TopCountDefault,
  parameter int MAX_LIST  = MaxListDefault
) (
  input logic       clk,
  input logic       rst,
  tkls_in_if.sink   entries,
  tkls_out_if.source results
);

  localparam int SeenW = $clog2(MAX_LIST + 1);

  typedef enum logic {
    COLLECT,
    EMIT
  } state_t;

  state_t            state;
  logic [SeenW-1:0]  seen;
  logic [CountW-1:0] count;
  logic [RankW-1:0]  rank_cnt;

  entry_t                 cell_q  [TOP_COUNT];
  logic                   take    [TOP_COUNT];
  entry_t                 upper_e [TOP_COUNT];
  logic                   upper_t [TOP_COUNT];
  entry_t                 lower_e [TOP_COUNT];
  logic [TOP_COUNT-1:0]   valid_vec;

  entry_t     new_entry;
  logic [31:0] seen_wide;
  logic       accept;
  logic       in_range;
  logic       insert_en;
  logic       out_free;
  logic       shift_en;
  logic       rank_last;

  assign entries.ready = (state == COLLECT);
  assign accept        = entries.valid && entries.ready;
  assign in_range      = seen < SeenW'(MAX_LIST);
  assign insert_en     = accept && entries.usable && in_range;
  assign out_free      = !results.valid || results.ready;
  assign shift_en      = (state == EMIT) && out_free;
  assign rank_last     = rank_cnt == RankW'(TOP_COUNT - 1);

  assign seen_wide               = 32'(seen);
  assign new_entry.load_value    = entries.load_value;
  assign new_entry.entry_id      = entries.entry_id;
  assign new_entry.list_position = seen_wide[PosW-1:0];
  assign new_entry.valid         = 1'b1;

  for (genvar k = 0; k < TOP_COUNT; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign upper_e[k] = '0;
      assign upper_t[k] = 1'b0;
    end else begin : g_body
      assign upper_e[k] = cell_q[k-1];
      assign upper_t[k] = take[k-1];
    end
    if (k == TOP_COUNT - 1) begin : g_tail
      assign lower_e[k] = '0;
    end else begin : g_inner
      assign lower_e[k] = cell_q[k+1];
    end
    assign valid_vec[k] = cell_q[k].valid;

    tkls_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .new_entry  (new_entry),
      .insert_en  (insert_en),
      .upper_entry(upper_e[k]),
      .upper_take (upper_t[k]),
      .lower_entry(lower_e[k]),
      .shift_en   (shift_en),
      .entry      (cell_q[k]),
      .take       (take[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= COLLECT;
      seen          <= '0;
      count         <= '0;
      rank_cnt      <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && !shift_en) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        COLLECT: begin
          if (accept) begin
            if (in_range) begin
              seen <= seen + SeenW'(1);
            end
            if (insert_en && count < CountW'(TOP_COUNT)) begin
              count <= count + CountW'(1);
            end
            if (entries.last_entry) begin
              state    <= EMIT;
              rank_cnt <= '0;
            end
          end
        end
        EMIT: begin
          if (out_free) begin
            results.valid          <= 1'b1;
            results.rank           <= rank_cnt;
            results.list_position  <= cell_q[0].valid ? cell_q[0].list_position : '0;
            results.present        <= cell_q[0].valid;
            results.selected_count <= count;
            results.last_result    <= rank_last;
            rank_cnt               <= rank_cnt + RankW'(1);
            if (rank_last) begin
              state <= COLLECT;
              seen  <= '0;
              count <= '0;
            end
          end
        end
        default: state <= COLLECT;
      endcase
    end
  end

  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    (state == COLLECT) |-> ($countones(valid_vec) == int'(count)))
    else $error("fill count disagrees with the occupied cells");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied cells are not a contiguous run from rank 0");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && entries.last_entry) |=> !entries.ready)
    else $error("request accepted before the read-out started");

  a_readout_done: assert property (@(posedge clk) disable iff (rst)
    (shift_en && rank_last) |=> (state == COLLECT && valid_vec == '0))
    else $error("chain not empty after the final rank was read out");

endmodule

[hdl/tkls_cell.sv]
module tkls_cell
  import tkls_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  entry_t new_entry,
  input  logic   insert_en,
  input  entry_t upper_entry,
  input  logic   upper_take,
  input  entry_t lower_entry,
  input  logic   shift_en,
  output entry_t entry,
  output logic   take
);

  // The newcomer belongs at or above this cell when the cell is empty or is beaten.
  assign take = !entry.valid || precedes(new_entry, entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift_en) begin
      entry <= lower_entry;
    end else if (insert_en && take) begin
      entry <= upper_take ? upper_entry : new_entry;
    end
  end

endmodule
